// ===== src/udpv_pkg.sv =====
// ----------------------------------------------------------------------------
// udpv_pkg
// Types, constants and helper functions shared by the udp frame header
// validator.
// ----------------------------------------------------------------------------
package udpv_pkg;

  localparam int unsigned CountW = 16;

  localparam logic [CountW-1:0] EthHdrBytes = 16'd14;
  localparam logic [CountW-1:0] IpMinBytes  = 16'd20;
  localparam logic [CountW-1:0] UdpHdrBytes = 16'd8;
  localparam logic [10:0]       WordBytes   = 11'd8;
  localparam logic [15:0]       Ipv4Kind    = 16'h0800;
  localparam logic [3:0]        IhlMin      = 4'd5;
  localparam logic [10:0]       MinPayloadReset = 11'd8;

  // byte positions of the captured header fields
  localparam logic [CountW-1:0] PosKindHi  = 16'd12;
  localparam logic [CountW-1:0] PosKindLo  = 16'd13;
  localparam logic [CountW-1:0] PosIhl     = 16'd14;
  localparam logic [CountW-1:0] PosTotalHi = 16'd16;
  localparam logic [CountW-1:0] PosTotalLo = 16'd17;

  // status codes
  localparam logic [2:0] StOk         = 3'd0;
  localparam logic [2:0] StShortEth   = 3'd1;
  localparam logic [2:0] StNotIpv4    = 3'd2;
  localparam logic [2:0] StShortIpHdr = 3'd3;
  localparam logic [2:0] StBadIhl     = 3'd4;
  localparam logic [2:0] StIpHdrCut   = 3'd5;
  localparam logic [2:0] StIpPktCut   = 3'd6;
  localparam logic [2:0] StUdpShort   = 3'd7;

  typedef struct packed {
    logic [CountW-1:0] len;
    logic [15:0]       ether_kind;
    logic [3:0]        header_words;
    logic [15:0]       ip_total_length;
    logic [10:0]       min_payload;
  } frame_info_t;

  // (r * 256 + b) mod 100 for r below 100, by reciprocal multiply
  // floor(x / 100) is exact for x below 25600 with 5243 / 2^19
  function automatic logic [6:0] residue_step(input logic [6:0] r, input logic [7:0] b);
    logic [14:0] x;
    logic [27:0] prod;
    logic [7:0]  q;
    logic [14:0] rem;
    x    = {r, b};
    prod = 28'(x) * 28'd5243;
    q    = prod[26:19];
    rem  = x - 15'(q) * 15'd100;
    return rem[6:0];
  endfunction

endpackage

// ===== src/udpv_in_if.sv =====
// ----------------------------------------------------------------------------
// udpv_in_if
// Frame byte channel: one frame byte per beat with a last-byte flag.
// ----------------------------------------------------------------------------
interface udpv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

// ===== src/udpv_out_if.sv =====
// ----------------------------------------------------------------------------
// udpv_out_if
// Result channel: one beat per frame with status, payload offset and count.
// ----------------------------------------------------------------------------
interface udpv_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [6:0] payload_offset;
  logic [6:0] request_count;

  modport source (output valid, output status, output payload_offset,
                  output request_count, input ready);
  modport sink   (input valid, input status, input payload_offset,
                  input request_count, output ready);
endinterface

// ===== src/udpv_check.sv =====
// ----------------------------------------------------------------------------
// udpv_check
// Header checks on a finished frame, first failing check sets the status.
// ----------------------------------------------------------------------------
module udpv_check (
  input  udpv_pkg::frame_info_t info,
  output logic [2:0]            status
);
  import udpv_pkg::*;

  logic [CountW-1:0] after_eth;
  logic [CountW-1:0] ihl_bytes;
  logic [CountW-1:0] rest;
  logic [10:0]       need;
  logic [CountW-1:0] need_total;

  always_comb begin
    after_eth  = info.len - EthHdrBytes;
    ihl_bytes  = {10'd0, info.header_words, 2'b00};
    rest       = after_eth - ihl_bytes;
    need       = (info.min_payload < WordBytes) ? WordBytes : info.min_payload;
    need_total = CountW'(need) + UdpHdrBytes;

    if (info.len < EthHdrBytes) begin
      status = StShortEth;
    end else if (info.ether_kind != Ipv4Kind) begin
      status = StNotIpv4;
    end else if (after_eth < IpMinBytes) begin
      status = StShortIpHdr;
    end else if (info.header_words < IhlMin) begin
      status = StBadIhl;
    end else if (after_eth < ihl_bytes) begin
      status = StIpHdrCut;
    end else if (after_eth < info.ip_total_length) begin
      status = StIpPktCut;
    end else if (rest < need_total) begin
      // covers both the missing udp header and the short payload
      status = StUdpShort;
    end else begin
      status = StOk;
    end
  end

endmodule

// ===== src/udp_frame_header_validator.sv =====
// ----------------------------------------------------------------------------
// udp_frame_header_validator
// A last byte passes the input register, then the result register.
// Throughput: one frame byte per cycle; an input register and a result
// register part the two channels, so the input stalls only while a result
// waits and the next last byte arrives. Reset clears all frame state, both
// valid flags and sets min_payload to 8.
// ----------------------------------------------------------------------------
module udp_frame_header_validator #(
  parameter int unsigned MAX_FRAME_BYTES = 65535
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [10:0]       cfg_wdata,
  udpv_in_if.sink           frame_in,
  udpv_out_if.source        result_out
);
  import udpv_pkg::*;

  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_FRAME_BYTES);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       advance;

  // frame state
  logic [10:0]       min_payload;
  logic [CountW-1:0] byte_count;
  logic [15:0]       ether_kind;
  logic [3:0]        header_words;
  logic [15:0]       ip_total_length;
  logic [6:0]        word_residue;

  logic [CountW-1:0] byte_count_next;
  logic [15:0]       ether_kind_next;
  logic [3:0]        header_words_next;
  logic [15:0]       ip_total_length_next;
  logic [6:0]        word_residue_next;

  logic [6:0]        offset;
  logic [CountW-1:0] offset_end;
  logic              in_word;
  frame_info_t       info;
  logic [2:0]        status_next;

  // result register
  logic       out_valid;
  logic [2:0] out_status;
  logic [6:0] out_offset;
  logic [6:0] out_count;

  assign advance = s1_valid && (!s1_last || !out_valid || result_out.ready);
  assign frame_in.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame_in.ready) begin
      s1_valid <= frame_in.valid;
    end
    if (frame_in.ready) begin
      s1_byte <= frame_in.frame_byte;
      s1_last <= frame_in.last_byte;
    end
  end

  always_comb begin
    offset     = 7'd22 + {1'b0, header_words, 2'b00};
    offset_end = CountW'(offset) + CountW'(WordBytes);
    in_word    = (byte_count > PosIhl) && (byte_count >= CountW'(offset)) &&
                 (byte_count < offset_end);

    ether_kind_next      = ether_kind;
    header_words_next    = header_words;
    ip_total_length_next = ip_total_length;
    case (byte_count)
      PosKindHi:  ether_kind_next[15:8]      = s1_byte;
      PosKindLo:  ether_kind_next[7:0]       = s1_byte;
      PosIhl:     header_words_next          = s1_byte[3:0];
      PosTotalHi: ip_total_length_next[15:8] = s1_byte;
      PosTotalLo: ip_total_length_next[7:0]  = s1_byte;
      default: ;
    endcase

    word_residue_next = in_word ? residue_step(word_residue, s1_byte) : word_residue;
    // counter sticks at the frame size limit
    byte_count_next   = (byte_count < MaxCount) ? byte_count + 1'b1 : byte_count;

    info.len             = byte_count_next;
    info.ether_kind      = ether_kind_next;
    info.header_words    = header_words_next;
    info.ip_total_length = ip_total_length_next;
    info.min_payload     = min_payload;
  end

  udpv_check u_check (
    .info   (info),
    .status (status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_payload     <= MinPayloadReset;
      byte_count      <= '0;
      ether_kind      <= '0;
      header_words    <= '0;
      ip_total_length <= '0;
      word_residue    <= '0;
    end else begin
      if (cfg_we) begin
        min_payload <= cfg_wdata;
      end
      if (advance) begin
        if (s1_last) begin
          byte_count      <= '0;
          ether_kind      <= '0;
          header_words    <= '0;
          ip_total_length <= '0;
          word_residue    <= '0;
        end else begin
          byte_count      <= byte_count_next;
          ether_kind      <= ether_kind_next;
          header_words    <= header_words_next;
          ip_total_length <= ip_total_length_next;
          word_residue    <= word_residue_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
    if (advance && s1_last) begin
      out_status <= status_next;
      out_offset <= (status_next == StOk) ? offset : 7'd0;
      out_count  <= (status_next == StOk) ? word_residue_next : 7'd0;
    end
  end

  assign result_out.valid          = out_valid;
  assign result_out.status         = out_status;
  assign result_out.payload_offset = out_offset;
  assign result_out.request_count  = out_count;

endmodule
